// ===== rtl/core/disk_request_min_location_queue_macros.svh =====
// ----------------------------------------------------------------------------
// disk request queue assertion macros
// shared property wrappers for the queue checker
// ----------------------------------------------------------------------------
`ifndef DISK_REQUEST_MIN_LOCATION_QUEUE_MACROS_SVH
`define DISK_REQUEST_MIN_LOCATION_QUEUE_MACROS_SVH

// clocked property, off while reset is asserted
`define DRMLQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a stalled beat keeps its contents
`define DRMLQ_ASSERT_HOLD(label, vld, rdy, sig, msg) \
	`DRMLQ_ASSERT(label, vld && !rdy |=> vld && $stable(sig), msg)

`endif

// ===== rtl/core/drmlq_pkg.sv =====
// ----------------------------------------------------------------------------
// drmlq_pkg
// shared types and constants of the disk request queue
// ----------------------------------------------------------------------------
package drmlq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 64;
	localparam int LOC_W      = 16;
	localparam int PROC_W     = 8;
	localparam int ENTRY_W    = LOC_W + PROC_W;
	localparam int QCOUNT_W   = 7;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SERVE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_SERVED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic insert;
		logic reject;
		logic empty;
		logic scan_clr;
		logic scan_rd;
		logic move;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op_serve;
		logic full;
		logic empty;
		logic rd_last;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/drmlq_datapath.sv =====
// ----------------------------------------------------------------------------
// drmlq_datapath
// request table memory, scan compare, count and result registers
// ----------------------------------------------------------------------------
module drmlq_datapath #(
	parameter int QUEUE_DEPTH = drmlq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  drmlq_pkg::cmd_t                  cmd,
	output drmlq_pkg::sts_t                  sts,
	input  logic                             in_op,
	input  logic [drmlq_pkg::IN_DATA_W-1:0]  in_data,
	input  logic                             cfg_we,
	input  logic                             cfg_bit,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [drmlq_pkg::OUT_DATA_W-1:0] out_data,
	output logic [1:0]                       out_status
);
	import drmlq_pkg::*;

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	logic [ENTRY_W-1:0]  mem_q [QUEUE_DEPTH];
	logic [ENTRY_W-1:0]  rd_data_s1;
	logic [ADDR_W-1:0]   rd_idx_s1;
	logic                rd_vld_s1;
	logic [ADDR_W-1:0]   rd_ptr_q;

	logic                op_q;
	logic [ENTRY_W-1:0]  req_q;
	logic                serve_largest_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    cnt_dec;
	logic [ADDR_W-1:0]   last_idx;
	logic [CNT_W+QCOUNT_W-1:0] cnt_ext;

	logic [ENTRY_W-1:0]  best_q;
	logic [ADDR_W-1:0]   best_idx_q;
	logic [ENTRY_W-1:0]  last_q;
	logic                better;

	status_t             res_status_q;
	logic [ENTRY_W-1:0]  res_entry_q;

	logic                m_valid_q;
	status_t             m_status_q;
	logic [ENTRY_W-1:0]  m_entry_q;
	logic [QCOUNT_W-1:0] m_qcnt_q;

	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0]  wr_data;

	assign cnt_dec  = count_q - CNT_W'(1);
	assign last_idx = cnt_dec[ADDR_W-1:0];
	assign cnt_ext  = {{QCOUNT_W{1'b0}}, count_q};

	assign wr_en   = cmd.insert | cmd.move;
	assign wr_addr = cmd.move ? best_idx_q : count_q[ADDR_W-1:0];
	assign wr_data = cmd.move ? last_q : req_q;

	// entry layout: proc above loc
	always_comb begin
		if (serve_largest_q) begin
			better = rd_data_s1[LOC_W-1:0] > best_q[LOC_W-1:0];
		end else begin
			better = rd_data_s1[LOC_W-1:0] < best_q[LOC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_ptr_q];
		rd_idx_s1  <= rd_ptr_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q <= in_data[ENTRY_W-1:0];
		end
		if (rd_vld_s1) begin
			if (rd_idx_s1 == '0 || better) begin
				best_q     <= rd_data_s1;
				best_idx_q <= rd_idx_s1;
			end
			if (rd_idx_s1 == last_idx) begin
				last_q <= rd_data_s1;
			end
		end
		if (cmd.insert) begin
			res_status_q <= ST_INSERTED;
			res_entry_q  <= '0;
		end else if (cmd.reject) begin
			res_status_q <= ST_FULL;
			res_entry_q  <= '0;
		end else if (cmd.empty) begin
			res_status_q <= ST_EMPTY;
			res_entry_q  <= '0;
		end else if (cmd.move) begin
			res_status_q <= ST_SERVED;
			res_entry_q  <= best_q;
		end
		if (cmd.out_load) begin
			m_status_q <= res_status_q;
			m_entry_q  <= res_entry_q;
			m_qcnt_q   <= cnt_ext[QCOUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q            <= 1'b0;
			serve_largest_q <= 1'b0;
			count_q         <= '0;
			rd_ptr_q        <= '0;
			rd_vld_s1       <= 1'b0;
			m_valid_q       <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				op_q <= in_op;
			end
			if (cfg_we) begin
				serve_largest_q <= cfg_bit;
			end
			if (cmd.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.move) begin
				count_q <= cnt_dec;
			end
			if (cmd.scan_clr) begin
				rd_ptr_q <= '0;
			end else if (cmd.scan_rd) begin
				rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
			end
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op_serve = (op_q == OP_SERVE);
	assign sts.full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign sts.empty    = (count_q == '0);
	assign sts.rd_last  = (rd_ptr_q == last_idx);
	assign sts.out_free = !m_valid_q || out_ready;

	assign out_valid  = m_valid_q;
	assign out_status = m_status_q;
	assign out_data   = {1'b0, m_qcnt_q, m_entry_q};

endmodule

// ===== rtl/core/drmlq_ctrl.sv =====
// ----------------------------------------------------------------------------
// drmlq_ctrl
// sequencer for insert, scan, move and result hand-off
// ----------------------------------------------------------------------------
module drmlq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  drmlq_pkg::sts_t sts,
	output drmlq_pkg::cmd_t cmd
);
	import drmlq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DRAIN,
		S_MOVE,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!sts.op_serve) begin
					cmd.reject = sts.full;
					cmd.insert = !sts.full;
					state_nxt  = S_RESULT;
				end else if (sts.empty) begin
					cmd.empty = 1'b1;
					state_nxt = S_RESULT;
				end else begin
					cmd.scan_clr = 1'b1;
					state_nxt    = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.rd_last) begin
					state_nxt = S_DRAIN;
				end
			end
			// last read word is compared here
			S_DRAIN: begin
				state_nxt = S_MOVE;
			end
			S_MOVE: begin
				cmd.move  = 1'b1;
				state_nxt = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/core/disk_request_min_location_queue.sv =====
// ----------------------------------------------------------------------------
// disk_request_min_location_queue
// disk request table that serves the nearest-edge location first
// ----------------------------------------------------------------------------
// Holds up to QUEUE_DEPTH waiting disk requests (16-bit location, 8-bit
// process) in a single-port-read, single-port-write memory. Every input beat
// yields exactly one output beat. An insert (tuser 0) appends the request at
// the table end, or is rejected with status full. A serve (tuser 1) scans all
// n waiting entries, one memory read per cycle, and returns the one with the
// smallest location (largest when the serve_largest bit is set), ties to the
// lowest position; the last entry then moves into the freed slot. An insert,
// a rejected insert and a serve from an empty table go from decode to the
// result state; a serve goes on through scan, drain and move. Items are
// processed one at a time; the next beat is taken while the previous result
// still waits in the output register. The user must write the configuration
// bit only while the block is idle; the block itself does not enforce this.
// The table needs no clearing after reset: only occupied entries are read.
// ----------------------------------------------------------------------------
module disk_request_min_location_queue #(
	parameter int QUEUE_DEPTH = drmlq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request side
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [drmlq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // request_loc, request_proc
	input  logic                             s_axis_tuser,  // operation
	// result side
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// served_loc, served_proc, queue_count, one zero pad bit
	output logic [drmlq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]                       m_axis_tuser,  // status
	// serve_largest register
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data
);
	import drmlq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// the register is a plain flop, always writable
	assign cfg_ready = 1'b1;

	drmlq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// memory, scan compare, count and output beat register
	drmlq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (s_axis_tuser),
		.in_data    (s_axis_tdata),
		.cfg_we     (cfg_valid),
		.cfg_bit    (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_status (m_axis_tuser)
	);

endmodule

// ===== rtl/core/drmlq_checker.sv =====
// ----------------------------------------------------------------------------
// drmlq_checker
// port-level checks of the disk request queue, bound to the top level
// ----------------------------------------------------------------------------
`include "disk_request_min_location_queue_macros.svh"

module drmlq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [drmlq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [1:0]                       m_axis_tuser
);
	import drmlq_pkg::*;

	// a stalled result beat holds
	`DRMLQ_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "result beat changed while stalled")

	// one item in flight: no request beat right after one was taken
	`DRMLQ_ASSERT(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")

	// only a served beat carries a location and process
	`DRMLQ_ASSERT(a_zero_unserved, m_axis_tvalid && m_axis_tuser != ST_SERVED |-> m_axis_tdata[23:0] == 24'd0, "nonzero payload on unserved beat")

	// an empty answer reports an empty table
	`DRMLQ_ASSERT(a_empty_count, m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[30:24] == 7'd0, "empty status with nonzero count")

endmodule

bind disk_request_min_location_queue drmlq_checker u_drmlq_checker (.*);
